// ----- hdl/sts_pkg.sv -----
// Shared types and constants for the SQL token scanner.
// No dependencies; used by every module of the block.
package sts_pkg;

   // Counter widths inside the scanner
   localparam int OFFSET_WIDTH = 16;
   localparam int LINE_WIDTH   = 16;

   // Widths of the result fields on the ports
   localparam int KIND_WIDTH  = 5;
   localparam int FIELD_WIDTH = 16;

   // Token queue between scanner and output stage
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Token kinds
   localparam logic [KIND_WIDTH-1:0] KIND_EOF     = 5'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_DOT     = 5'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_COMMA   = 5'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_EQ      = 5'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_NEQ     = 5'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_LT      = 5'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_GT      = 5'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_STAR    = 5'd7;
   localparam logic [KIND_WIDTH-1:0] KIND_PLUS    = 5'd8;
   localparam logic [KIND_WIDTH-1:0] KIND_MINUS   = 5'd9;
   localparam logic [KIND_WIDTH-1:0] KIND_SLASH   = 5'd10;
   localparam logic [KIND_WIDTH-1:0] KIND_STRING  = 5'd11;
   localparam logic [KIND_WIDTH-1:0] KIND_IDENT   = 5'd12;
   localparam logic [KIND_WIDTH-1:0] KIND_SELECT  = 5'd13;
   localparam logic [KIND_WIDTH-1:0] KIND_FROM    = 5'd14;
   localparam logic [KIND_WIDTH-1:0] KIND_WHERE   = 5'd15;
   localparam logic [KIND_WIDTH-1:0] KIND_OR      = 5'd16;
   localparam logic [KIND_WIDTH-1:0] KIND_AND     = 5'd17;
   localparam logic [KIND_WIDTH-1:0] KIND_NUMBER  = 5'd18;
   localparam logic [KIND_WIDTH-1:0] KIND_INVALID = 5'd19;
   localparam logic [KIND_WIDTH-1:0] KIND_UNTERM  = 5'd20;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [FIELD_WIDTH-1:0] start;
      logic [FIELD_WIDTH-1:0] len;
      logic [FIELD_WIDTH-1:0] line;
      logic [FIELD_WIDTH-1:0] col;
   } token_type;

   // All tokens caused by one source byte; tok0 always used, tok1 only if two
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } group_type;

endpackage

// ----- hdl/sts_front.sv -----
// Scanner front end: takes one source byte per transfer and forms its tokens.
// Depends on sts_pkg; feeds sts_queue.
module sts_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_source_byte,
   input  logic               queue_full,
   output logic               push,
   output sts_pkg::group_type push_data
);
   import sts_pkg::*;

   localparam int CALC_WIDTH = (OFFSET_WIDTH > LINE_WIDTH ? OFFSET_WIDTH : LINE_WIDTH) + 1;
   localparam int KW_COUNT   = 5;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_UNDER = 8'h5f;

   // Keyword text, left aligned in 48 bits
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      "select", {"from", 16'h0000}, {"where", 8'h00}, {"or", 32'h0}, {"and", 24'h0}};
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd4, 3'd5, 3'd2, 3'd3};

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LT,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING
   } mode_type;

   typedef struct packed {
      logic [2:0] idx;
      logic [4:0] mask;
   } kw_type;

   localparam kw_type KW_RESET = '{idx: 3'd0, mask: 5'b11111};

   function automatic logic is_alpha(logic [7:0] ch);
      return ch inside {[8'h61:8'h7a], [8'h41:8'h5a], CH_UNDER};
   endfunction

   function automatic logic is_digit(logic [7:0] ch);
      return ch inside {[8'h30:8'h39]};
   endfunction

   function automatic kw_type kw_step(kw_type kw, logic [7:0] ch);
      kw_type r;
      r = kw;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (kw.mask[k]) begin
            if (kw.idx >= KW_LEN[k]) begin
               r.mask[k] = 1'b0;
            end else if (KW_TEXT[k][47 - 8*int'(kw.idx) -: 8] != ch) begin
               r.mask[k] = 1'b0;
            end
         end
      end
      if (kw.idx != 3'd7) begin
         r.idx = kw.idx + 3'd1;
      end
      return r;
   endfunction

   // First surviving keyword whose length matches wins
   function automatic logic [KIND_WIDTH-1:0] ident_kind(kw_type kw);
      logic [KIND_WIDTH-1:0] kind;
      kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (kw.mask[k] && KW_LEN[k] == kw.idx) begin
            kind = KIND_SELECT + KIND_WIDTH'(k);
         end
      end
      return kind;
   endfunction

   function automatic token_type make_token(
      logic [KIND_WIDTH-1:0]   kind,
      logic [OFFSET_WIDTH-1:0] off,
      logic [OFFSET_WIDTH-1:0] plen,
      logic [LINE_WIDTH-1:0]   line,
      logic [LINE_WIDTH-1:0]   col
   );
      token_type               t;
      logic [OFFSET_WIDTH-1:0] start;
      logic [CALC_WIDTH-1:0]   col1;
      logic [CALC_WIDTH-1:0]   plen_w;
      logic [CALC_WIDTH-1:0]   col_start;
      start     = (off >= plen) ? off - plen : '0;
      col1      = CALC_WIDTH'(col) + CALC_WIDTH'(1);
      plen_w    = CALC_WIDTH'(plen);
      col_start = (col1 >= plen_w) ? col1 - plen_w : '0;
      t.kind    = kind;
      t.start   = FIELD_WIDTH'(start);
      t.len     = FIELD_WIDTH'(plen);
      t.line    = FIELD_WIDTH'(line);
      t.col     = FIELD_WIDTH'(col_start);
      return t;
   endfunction

   function automatic logic [OFFSET_WIDTH-1:0] sat_off(logic [OFFSET_WIDTH-1:0] v);
      return (v == '1) ? v : v + OFFSET_WIDTH'(1);
   endfunction

   function automatic logic [LINE_WIDTH-1:0] sat_line(logic [LINE_WIDTH-1:0] v);
      return (v == '1) ? v : v + LINE_WIDTH'(1);
   endfunction

   mode_type                mode_ff, mode_in;
   kw_type                  kw_ff, kw_in;
   logic [OFFSET_WIDTH-1:0] off_ff, off_in;
   logic [OFFSET_WIDTH-1:0] plen_ff, plen_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;
   logic [LINE_WIDTH-1:0]   col_ff, col_in;

   logic      accept;
   logic      emit_a, emit_b;
   token_type tok_a, tok_b;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      logic       done;
      logic [7:0] ch;
      ch      = req_source_byte;
      done    = 1'b0;
      mode_in = mode_ff;
      kw_in   = kw_ff;
      off_in  = off_ff;
      plen_in = plen_ff;
      line_in = line_ff;
      col_in  = col_ff;
      emit_a  = 1'b0;
      emit_b  = 1'b0;
      tok_a   = '0;
      tok_b   = '0;

      // Close or extend the pending token
      case (mode_ff)
         MODE_LT: begin
            if (ch == CH_GT) begin
               off_in  = sat_off(off_in);
               plen_in = sat_off(plen_in);
               col_in  = sat_line(col_in);
               emit_a  = 1'b1;
               tok_a   = make_token(KIND_NEQ, off_in, plen_in, line_in, col_in);
               done    = 1'b1;
            end else begin
               emit_a = 1'b1;
               tok_a  = make_token(KIND_LT, off_in, plen_in, line_in, col_in);
            end
            plen_in = emit_a ? '0 : plen_in;
            mode_in = MODE_IDLE;
         end
         MODE_IDENT: begin
            if (is_alpha(ch) || is_digit(ch)) begin
               off_in  = sat_off(off_in);
               plen_in = sat_off(plen_in);
               col_in  = sat_line(col_in);
               kw_in   = kw_step(kw_ff, ch);
               done    = 1'b1;
            end else begin
               emit_a  = 1'b1;
               tok_a   = make_token(ident_kind(kw_ff), off_in, plen_in, line_in, col_in);
               plen_in = '0;
               mode_in = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(ch)) begin
               off_in  = sat_off(off_in);
               plen_in = sat_off(plen_in);
               col_in  = sat_line(col_in);
               done    = 1'b1;
            end else begin
               emit_a  = 1'b1;
               tok_a   = make_token(KIND_NUMBER, off_in, plen_in, line_in, col_in);
               plen_in = '0;
               mode_in = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (ch == CH_NUL) begin
               emit_a  = 1'b1;
               tok_a   = make_token(KIND_UNTERM, off_in, plen_in, line_in, col_in);
               plen_in = '0;
               mode_in = MODE_IDLE;
            end else begin
               off_in  = sat_off(off_in);
               plen_in = sat_off(plen_in);
               col_in  = sat_line(col_in);
               if (ch == CH_QUOTE) begin
                  emit_a  = 1'b1;
                  tok_a   = make_token(KIND_STRING, off_in, plen_in, line_in, col_in);
                  plen_in = '0;
                  mode_in = MODE_IDLE;
               end
               done = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // Scan the byte afresh between tokens
      if (!done) begin
         off_in  = sat_off(off_in);
         plen_in = sat_off(plen_in);
         col_in  = sat_line(col_in);
         case (ch)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
               if (ch == CH_LF) begin
                  line_in = sat_line(line_in);
                  col_in  = '0;
               end
               plen_in = '0;
            end
            CH_NUL: begin
               emit_b  = 1'b1;
               tok_b   = make_token(KIND_EOF, off_in, plen_in, line_in, col_in);
               mode_in = MODE_IDLE;
               kw_in   = KW_RESET;
               off_in  = '0;
               plen_in = '0;
               line_in = LINE_WIDTH'(1);
               col_in  = '0;
            end
            CH_DOT, CH_COMMA, CH_EQ, CH_GT, CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH: begin
               emit_b = 1'b1;
               case (ch)
                  CH_DOT:   tok_b = make_token(KIND_DOT, off_in, plen_in, line_in, col_in);
                  CH_COMMA: tok_b = make_token(KIND_COMMA, off_in, plen_in, line_in, col_in);
                  CH_EQ:    tok_b = make_token(KIND_EQ, off_in, plen_in, line_in, col_in);
                  CH_GT:    tok_b = make_token(KIND_GT, off_in, plen_in, line_in, col_in);
                  CH_STAR:  tok_b = make_token(KIND_STAR, off_in, plen_in, line_in, col_in);
                  CH_PLUS:  tok_b = make_token(KIND_PLUS, off_in, plen_in, line_in, col_in);
                  CH_MINUS: tok_b = make_token(KIND_MINUS, off_in, plen_in, line_in, col_in);
                  default:  tok_b = make_token(KIND_SLASH, off_in, plen_in, line_in, col_in);
               endcase
               plen_in = '0;
            end
            CH_LT: begin
               mode_in = MODE_LT;
            end
            CH_QUOTE: begin
               mode_in = MODE_STRING;
            end
            default: begin
               if (is_alpha(ch)) begin
                  kw_in   = kw_step(KW_RESET, ch);
                  mode_in = MODE_IDENT;
               end else if (is_digit(ch)) begin
                  mode_in = MODE_NUMBER;
               end else begin
                  emit_b  = 1'b1;
                  tok_b   = make_token(KIND_INVALID, off_in, plen_in, line_in, col_in);
                  plen_in = '0;
               end
            end
         endcase
      end
   end

   assign push           = accept && (emit_a || emit_b);
   assign push_data.two  = emit_a && emit_b;
   assign push_data.tok0 = emit_a ? tok_a : tok_b;
   assign push_data.tok1 = tok_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         kw_ff   <= KW_RESET;
         off_ff  <= '0;
         plen_ff <= '0;
         line_ff <= LINE_WIDTH'(1);
         col_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kw_ff   <= kw_in;
         off_ff  <= off_in;
         plen_ff <= plen_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

endmodule

// ----- hdl/sts_queue.sv -----
// Short token-group queue between scanner front end and output stage.
// Depends on sts_pkg.
module sts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sts_pkg::group_type push_data,
   input  logic               pop,
   output sts_pkg::group_type head_data,
   output logic               empty,
   output logic               full
);
   import sts_pkg::*;

   group_type                    store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign head_data = store_ff[rd_ptr_ff];
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QUEUE_COUNT_WIDTH'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/sts_back.sv -----
// Output stage: splits each token group into single result transfers.
// Depends on sts_pkg; drains sts_queue.
module sts_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sts_pkg::group_type                    head_data,
   input  logic                                  head_empty,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sts_pkg::KIND_WIDTH-1:0]        rsp_token_kind,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_start_offset,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_token_len,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_line_number,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_column_number,
   output logic                                  rsp_last_of_run
);
   import sts_pkg::*;

   logic      valid_ff, valid_in;
   logic      half_ff, half_in;   // second token of the head group is next
   token_type tok_ff, tok_in;
   logic      last_ff, last_in;
   logic      load;

   assign load = !head_empty && (!valid_ff || !rsp_stall);
   assign pop  = load && (half_ff || !head_data.two);

   always_comb begin
      tok_in   = half_ff ? head_data.tok1 : head_data.tok0;
      last_in  = half_ff || !head_data.two;
      valid_in = load || (valid_ff && rsp_stall);
      half_in  = half_ff;
      if (load) begin
         half_in = !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= tok_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_token_kind    = tok_ff.kind;
   assign rsp_start_offset  = tok_ff.start;
   assign rsp_token_len     = tok_ff.len;
   assign rsp_line_number   = tok_ff.line;
   assign rsp_column_number = tok_ff.col;
   assign rsp_last_of_run   = last_ff;

endmodule

// ----- hdl/sql_token_scanner.sv -----
// SQL token scanner top level: front end, token queue and output stage.
// Depends on sts_pkg, sts_front, sts_queue and sts_back.
//
// Source text enters one byte per req_ transfer; a zero byte ends the source,
// emits an end-of-source token and returns the scanner to its reset state.
// Tokens leave one per rsp_ transfer with kind, start offset, length, line,
// one-based column and a flag on the last token caused by a given byte.
// The scanner takes one byte per cycle unless req_stall is high: all
// classification and counter updates for a byte sit in the front end. A byte
// that closes a pending token and also forms its own yields two tokens, which
// the output stage hands out as two transfers; a four-entry queue of token
// groups sits between the two parts, so req_stall rises only when that queue
// is full (output held back, or a long run of two-token bytes). The first
// token of a byte passes through the queue and the output register to rsp_.
// Bytes that produce no token (whitespace, the inside of identifiers,
// numbers and strings) take no queue space.
module sql_token_scanner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_source_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sts_pkg::KIND_WIDTH-1:0]        rsp_token_kind,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_start_offset,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_token_len,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_line_number,
   output logic [sts_pkg::FIELD_WIDTH-1:0]       rsp_column_number,
   output logic                                  rsp_last_of_run
);
   import sts_pkg::*;

   logic      push, pop;
   logic      queue_empty, queue_full;
   group_type push_data, head_data;

   // Classify bytes and build tokens
   sts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_source_byte (req_source_byte),
      .queue_full      (queue_full),
      .push            (push),
      .push_data       (push_data)
   );

   // Decouples scanning from the result side
   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // One result transfer per token
   sts_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_data         (head_data),
      .head_empty        (queue_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_token_len     (rsp_token_len),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ----- bench/token_stream_checker.sv -----
// Token checker for the SQL token scanner: watches both channels, predicts
// the tokens of every byte transfer and compares them field by field.
// Depends on sts_pkg for token kinds, counter widths and the token struct.
module token_stream_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_source_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sts_pkg::KIND_WIDTH-1:0]  rsp_token_kind,
   input  logic [sts_pkg::FIELD_WIDTH-1:0] rsp_start_offset,
   input  logic [sts_pkg::FIELD_WIDTH-1:0] rsp_token_len,
   input  logic [sts_pkg::FIELD_WIDTH-1:0] rsp_line_number,
   input  logic [sts_pkg::FIELD_WIDTH-1:0] rsp_column_number,
   input  logic                            rsp_last_of_run,
   output int                              fault_count,
   output int                              waiting_count
);
   import sts_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LT,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING
   } scan_mode_type;

   typedef struct packed {
      token_type tok;
      logic      last;
   } token_item_type;

   localparam longint unsigned OFFSET_MAX   = (64'd1 << OFFSET_WIDTH) - 64'd1;
   localparam longint unsigned LINE_MAX     = (64'd1 << LINE_WIDTH) - 64'd1;
   localparam logic [4:0]      ALL_KEYWORDS = 5'b11111;
   localparam logic [7:0]      END_BYTE     = 8'h00;
   localparam logic [7:0]      QUOTE        = 8'h27;

   string keyword_text [5] = '{"select", "from", "where", "or", "and"};

   // predicted scanner state
   scan_mode_type   mode;
   logic [4:0]      kw_live;
   logic [2:0]      kw_pos;
   longint unsigned offset_cnt;
   longint unsigned run_len;
   longint unsigned line_cnt;
   longint unsigned col_cnt;

   token_item_type  step_buf [2];
   int              step_count;
   token_item_type  expected_tokens [$];

   function automatic longint unsigned sat_inc(longint unsigned v, longint unsigned top);
      return (v < top) ? v + 64'd1 : top;
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void clear_scanner();
      mode       = MODE_IDLE;
      kw_live    = ALL_KEYWORDS;
      kw_pos     = 3'd0;
      offset_cnt = 64'd0;
      run_len    = 64'd0;
      line_cnt   = 64'd1;
      col_cnt    = 64'd0;
   endfunction

   function automatic void take_byte();
      offset_cnt = sat_inc(offset_cnt, OFFSET_MAX);
      run_len    = sat_inc(run_len, OFFSET_MAX);
      col_cnt    = sat_inc(col_cnt, LINE_MAX);
   endfunction

   function automatic void close_token(logic [KIND_WIDTH-1:0] kind);
      longint unsigned first;
      longint unsigned column;
      token_item_type  item;
      if (step_count >= 2)
         return;
      first  = (offset_cnt >= run_len) ? offset_cnt - run_len : 64'd0;
      column = (col_cnt + 64'd1 >= run_len) ? col_cnt + 64'd1 - run_len : 64'd0;
      item.tok.kind  = kind;
      item.tok.start = first[FIELD_WIDTH-1:0];
      item.tok.len   = run_len[FIELD_WIDTH-1:0];
      item.tok.line  = line_cnt[FIELD_WIDTH-1:0];
      item.tok.col   = column[FIELD_WIDTH-1:0];
      item.last      = 1'b0;
      step_buf[step_count] = item;
      step_count++;
      run_len = 64'd0;
   endfunction

   // drop every keyword that cannot match once this letter is added
   function automatic void match_keyword(logic [7:0] c);
      for (int k = 0; k < 5; k++) begin
         if (kw_live[k] && (kw_pos >= keyword_text[k].len() || keyword_text[k][kw_pos] != c))
            kw_live[k] = 1'b0;
      end
      if (kw_pos < 3'd7)
         kw_pos = kw_pos + 3'd1;
   endfunction

   function automatic logic [KIND_WIDTH-1:0] word_kind();
      for (int k = 0; k < 5; k++) begin
         if (kw_live[k] && keyword_text[k].len() == kw_pos)
            return KIND_SELECT + KIND_WIDTH'(k);
      end
      return KIND_IDENT;
   endfunction

   // byte seen with no token open
   function automatic void scan_fresh(logic [7:0] c);
      take_byte();
      case (c)
         " ", "\t", "\r", "\n": begin
            if (c == "\n") begin
               line_cnt = sat_inc(line_cnt, LINE_MAX);
               col_cnt  = 64'd0;
            end
            run_len = 64'd0;
         end
         END_BYTE: begin
            close_token(KIND_EOF);
            clear_scanner();
         end
         ".": close_token(KIND_DOT);
         ",": close_token(KIND_COMMA);
         "=": close_token(KIND_EQ);
         ">": close_token(KIND_GT);
         "*": close_token(KIND_STAR);
         "+": close_token(KIND_PLUS);
         "-": close_token(KIND_MINUS);
         "/": close_token(KIND_SLASH);
         "<": mode = MODE_LT;
         QUOTE: mode = MODE_STRING;
         default: begin
            if (is_letter(c)) begin
               kw_live = ALL_KEYWORDS;
               kw_pos  = 3'd0;
               match_keyword(c);
               mode = MODE_IDENT;
            end else if (is_digit(c)) begin
               mode = MODE_NUMBER;
            end else begin
               close_token(KIND_INVALID);
            end
         end
      endcase
   endfunction

   // one byte transfer: close any open token, then scan the byte afresh
   function automatic void scan_byte(logic [7:0] c);
      logic           taken;
      token_item_type item;
      taken      = 1'b0;
      step_count = 0;
      case (mode)
         MODE_LT: begin
            if (c == ">") begin
               take_byte();
               close_token(KIND_NEQ);
               taken = 1'b1;
            end else begin
               close_token(KIND_LT);
            end
            mode = MODE_IDLE;
         end
         MODE_IDENT: begin
            if (is_letter(c) || is_digit(c)) begin
               take_byte();
               match_keyword(c);
               taken = 1'b1;
            end else begin
               close_token(word_kind());
               mode = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               take_byte();
               taken = 1'b1;
            end else begin
               close_token(KIND_NUMBER);
               mode = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (c == END_BYTE) begin
               close_token(KIND_UNTERM);
               mode = MODE_IDLE;
            end else begin
               take_byte();
               if (c == QUOTE) begin
                  close_token(KIND_STRING);
                  mode = MODE_IDLE;
               end
               taken = 1'b1;
            end
         end
         default: mode = MODE_IDLE;
      endcase
      if (!taken)
         scan_fresh(c);
      for (int i = 0; i < step_count; i++) begin
         item      = step_buf[i];
         item.last = (i == step_count - 1);
         expected_tokens = {expected_tokens, item};
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      token_item_type want;
      if (reset) begin
         clear_scanner();
         expected_tokens.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: expected no token, got kind %0d at offset %0d",
                        $time, rsp_token_kind, rsp_start_offset);
               fault_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", 32'(want.tok.kind), 32'(rsp_token_kind));
               check_field("start_offset", 32'(want.tok.start), 32'(rsp_start_offset));
               check_field("token_len", 32'(want.tok.len), 32'(rsp_token_len));
               check_field("line_number", 32'(want.tok.line), 32'(rsp_line_number));
               check_field("column_number", 32'(want.tok.col), 32'(rsp_column_number));
               check_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
            end
         end
         if (req_valid && !req_stall)
            scan_byte(req_source_byte);
      end
      waiting_count = expected_tokens.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// Bench top for the SQL token scanner: clock, reset, source text stimulus,
// random stalls on the token side and the verdict.
// Depends on sts_pkg, sql_token_scanner and token_stream_checker.
module tb_top;
   import sts_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000; // whole run, far above a stalled run
   localparam int SOURCE_BYTES  = 950;       // random sources start until this many bytes are sent
   localparam int DRAIN_LIMIT   = 5_000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [7:0] END_BYTE = 8'h00;
   localparam logic [7:0] QUOTE    = 8'h27;

   localparam string LEAD_CHARS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string TAIL_CHARS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   localparam string DIGIT_CHARS = "0123456789";
   localparam string PUNCT_CHARS = ".,=<>*+-/";
   localparam string SPACE_CHARS = " \t\r\n";

   string keyword_list [5] = '{"select", "from", "where", "or", "and"};

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_source_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic [KIND_WIDTH-1:0]  rsp_token_kind;
   logic [FIELD_WIDTH-1:0] rsp_start_offset;
   logic [FIELD_WIDTH-1:0] rsp_token_len;
   logic [FIELD_WIDTH-1:0] rsp_line_number;
   logic [FIELD_WIDTH-1:0] rsp_column_number;
   logic                   rsp_last_of_run;

   int fault_count;
   int waiting_count;
   int cycle_count = 0;
   int bytes_sent  = 0;
   bit send_quiet  = 1'b0;   // stretch with no gaps between byte transfers
   bit take_quiet  = 1'b0;   // stretch with no stalls on the token side

   sql_token_scanner DUT (.*);

   // predicts, compares and counts failures; this module makes stimulus and the verdict
   token_stream_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // content byte of a quoted string: anything but the quote and the end byte,
   // with line feeds now and then since they must not move the line count
   function automatic logic [7:0] string_byte();
      logic [7:0] b;
      if ($urandom_range(0, 5) == 0)
         return "\n";
      do b = 8'($urandom_range(1, 255)); while (b == QUOTE);
      return b;
   endfunction

   // One byte transfer. The gap before it is drawn per byte; valid stays high
   // from one byte to the next when the gap is zero, and the byte is held
   // until the edge at which stall is low.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_source_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   // one well-formed token, a near miss of a keyword, or a stray byte
   task automatic push_lexeme();
      string word;
      case ($urandom_range(0, 9))
         0, 1: begin
            word = keyword_list[$urandom_range(0, 4)];
            case ($urandom_range(0, 3))
               0: push_text(word.substr(0, word.len() - 2));   // prefix: plain identifier
               1: push_text(word.toupper());                   // keywords are lowercase only
               2: begin
                  push_text(word);                             // one character too many
                  push_byte(pick(TAIL_CHARS));
               end
               default: push_text(word);
            endcase
         end
         2, 3: begin
            push_byte(pick(LEAD_CHARS));
            repeat ($urandom_range(0, 7)) push_byte(pick(TAIL_CHARS));
         end
         4: repeat ($urandom_range(1, 5)) push_byte(pick(DIGIT_CHARS));
         5: begin
            push_byte(QUOTE);
            repeat ($urandom_range(0, 6)) push_byte(string_byte());
            push_byte(QUOTE);
         end
         6: push_text("<>");
         7, 8: push_byte(pick(PUNCT_CHARS));
         default: push_byte(8'($urandom_range(1, 255)));
      endcase
   endtask

   // A whole source ending in the end byte. Tokens often touch with no space
   // between them, so one byte closes the previous token and opens its own.
   task automatic push_source();
      repeat ($urandom_range(0, 30)) begin
         push_lexeme();
         if ($urandom_range(0, 4) < 3)
            repeat ($urandom_range(1, 2)) push_byte(pick(SPACE_CHARS));
      end
      // now and then leave a string open so that the end byte must close it
      if ($urandom_range(0, 7) == 0) begin
         push_byte(QUOTE);
         repeat ($urandom_range(0, 4)) push_byte(string_byte());
      end
      push_byte(END_BYTE);
   endtask

   // Token side: stall for a drawn number of cycles, then drop stall and wait
   // for the transfer. Stall changes at most once per edge.
   initial begin
      int hold;
      forever begin
         if ($urandom_range(0, 39) == 0)
            take_quiet = !take_quiet;
         hold = take_quiet ? 0 : $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed source: every operator and punctuation mark, '<' closed by
      // another token, a string holding a line feed, a number closed by a
      // letter, an identifier closed by an invalid top-bit byte, and a string
      // left open at the end byte (unterminated token followed by end).
      push_text("<><*.,=>+-/ '\n'7a\377'\tq\r");
      push_byte(END_BYTE);

      // random sources of mostly well-formed tokens
      while (bytes_sent < SOURCE_BYTES)
         push_source();

      req_valid <= 1'b0;
      @(posedge clock);

      // drain: every predicted token must come out, then a quiet spell
      // catches any token the block should not have made
      for (int w = 0; w < DRAIN_LIMIT && waiting_count != 0; w++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0 && waiting_count == 0) begin
         $display("TEST PASSED");
      end else begin
         if (waiting_count != 0)
            $display("%0t: expected %0d more tokens, got none", $time, waiting_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
